FILE: hw/rtl/dpzz_pkg.sv
// shared types and constants for the dpcm zigzag pixel codec
package dpzz_pkg;

  localparam int unsigned MaxChannels = 3;
  localparam int unsigned DataW       = 8;
  localparam int unsigned WarmW       = $clog2(MaxChannels + 1);
  localparam int unsigned CfgIdxW     = 1;
  localparam int unsigned CfgDataW    = 1;

  typedef logic [DataW-1:0] data_t;
  typedef logic [WarmW-1:0] warm_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DIRECTION  = 1'b0,
    CFG_COLOR_MODE = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    DIR_ENCODE = 1'b0,
    DIR_DECODE = 1'b1
  } dir_e;

  typedef struct packed {
    logic  advance;
    logic  restart;
    logic  color_mode;
    logic  write;
    data_t wdata;
  } cell_ctrl_t;

endpackage

FILE: hw/rtl/dpzz_if.sv
// request and result channels of the dpcm zigzag pixel codec
interface dpzz_in_if;
  import dpzz_pkg::*;

  logic  valid;
  logic  ready;
  data_t sample;
  logic  last_of_image;

  modport source (output valid, output sample, output last_of_image, input ready);
  modport sink (input valid, input sample, input last_of_image, output ready);
endinterface

interface dpzz_out_if;
  import dpzz_pkg::*;

  logic  valid;
  logic  ready;
  data_t out_byte;
  logic  out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

FILE: hw/rtl/dpzz_cell.sv
// one channel cell: reference byte and rotating channel token
module dpzz_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               home_i,
  input  logic               token_i,
  output logic               token_o,
  input  dpzz_pkg::cell_ctrl_t ctrl_i,
  input  dpzz_pkg::data_t    ref_i,
  output dpzz_pkg::data_t    ref_o
);
  import dpzz_pkg::*;

  logic  token_q, token_d;
  data_t ref_q, ref_d;
  logic  sel;

  assign sel     = ctrl_i.color_mode ? token_q : home_i;
  assign token_o = token_q;
  assign ref_o   = ref_i | (sel ? ref_q : '0);

  always_comb begin
    token_d = token_q;
    if (ctrl_i.advance) begin
      token_d = ctrl_i.restart ? home_i : token_i;
    end
  end

  always_comb begin
    ref_d = ref_q;
    if (ctrl_i.write && sel) begin
      ref_d = ctrl_i.wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      token_q <= home_i;
      ref_q   <= '0;
    end else begin
      token_q <= token_d;
      ref_q   <= ref_d;
    end
  end

endmodule

FILE: hw/rtl/dpzz_datapath.sv
// encode and decode arithmetic for one byte
module dpzz_datapath (
  input  dpzz_pkg::data_t sample_i,
  input  dpzz_pkg::data_t ref_i,
  input  dpzz_pkg::dir_e  direction_i,
  input  logic            passthrough_i,
  output dpzz_pkg::data_t result_o,
  output dpzz_pkg::data_t new_ref_o
);
  import dpzz_pkg::*;

  logic [DataW:0]   diff;
  logic [DataW:0]   twice_q;
  data_t            enc_code;
  data_t            enc_ref;
  logic [DataW:0]   dec_x;
  logic [DataW+1:0] dec_sum;
  data_t            dec_val;

  // halve toward zero, keep twice the quotient
  assign diff    = {1'b0, sample_i} - {1'b0, ref_i};
  assign twice_q = diff[DataW] ? (diff + {{DataW{1'b0}}, diff[0]})
                               : {diff[DataW:1], 1'b0};
  assign enc_code = twice_q[DataW] ? ~twice_q[DataW-1:0] : twice_q[DataW-1:0];
  assign enc_ref  = ref_i + twice_q[DataW-1:0];

  // odd code maps to -(code + 1)
  assign dec_x   = sample_i[0] ? ~{1'b0, sample_i} : {1'b0, sample_i};
  assign dec_sum = {2'b00, ref_i} + {dec_x[DataW], dec_x};
  assign dec_val = (!dec_sum[DataW+1] && dec_sum[DataW]) ? '1 : dec_sum[DataW-1:0];

  always_comb begin
    if (passthrough_i) begin
      result_o  = sample_i;
      new_ref_o = sample_i;
    end else if (direction_i == DIR_ENCODE) begin
      result_o  = enc_code;
      new_ref_o = enc_ref;
    end else begin
      result_o  = dec_val;
      new_ref_o = dec_val;
    end
  end

endmodule

FILE: hw/rtl/dpzz_pixel_codec_top.sv
// top level of the dpcm zigzag pixel codec
// The codec takes one byte per cycle while its skid stage is empty and returns one
// byte per request through an output register backed by a one-entry skid
// stage, so input and output stalls are decoupled. The per-channel references
// live in a ring of MaxChannels cells; a one-hot token passes from cell to cell
// on every accepted byte and returns to the first cell at the end of an image or
// in grayscale mode. The selected reference feeds a single combinational add, halve and
// zigzag (or unzigzag and add) stage, so one byte per clock is sustained while the output is not stalled.
// Configuration writes take effect on the next byte and are meant to happen
// while the codec is idle.
module dpcm_zigzag_pixel_codec (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [dpzz_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dpzz_pkg::CfgDataW-1:0] cfg_wdata_i,
  dpzz_in_if.sink                    in_i,
  dpzz_out_if.source                 out_o
);
  import dpzz_pkg::*;

  dir_e  direction_q;
  logic  color_mode_q;
  warm_t warm_q, warm_d;
  warm_t num_ch;
  logic  passthrough;
  logic  in_fire, out_fire;

  logic [MaxChannels-1:0] token_out;
  logic [MaxChannels-1:0] token_in;
  data_t                  ref_chain [MaxChannels+1];
  cell_ctrl_t             cell_ctrl;
  data_t                  result, new_ref;

  logic  out_valid_q, out_valid_d;
  data_t out_byte_q, out_byte_d;
  logic  out_last_q, out_last_d;
  logic  skid_valid_q, skid_valid_d;
  data_t skid_byte_q, skid_byte_d;
  logic  skid_last_q, skid_last_d;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direction_q  <= DIR_ENCODE;
      color_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_DIRECTION:  direction_q  <= dir_e'(cfg_wdata_i[0]);
        CFG_COLOR_MODE: color_mode_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign in_i.ready = !skid_valid_q;
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = out_valid_q && out_o.ready;

  // warm-up counter
  assign num_ch      = color_mode_q ? WarmW'(MaxChannels) : WarmW'(1);
  assign passthrough = warm_q < num_ch;

  always_comb begin
    warm_d = warm_q;
    if (in_fire) begin
      if (in_i.last_of_image) begin
        warm_d = '0;
      end else if (passthrough) begin
        warm_d = warm_q + WarmW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warm_q <= '0;
    end else begin
      warm_q <= warm_d;
    end
  end

  // ring of channel cells
  assign cell_ctrl.advance    = in_fire;
  assign cell_ctrl.restart    = in_i.last_of_image || !color_mode_q;
  assign cell_ctrl.color_mode = color_mode_q;
  assign cell_ctrl.write      = in_fire;
  assign cell_ctrl.wdata      = new_ref;
  assign ref_chain[0]         = '0;

  for (genvar i = 0; i < MaxChannels; i++) begin : g_cell
    localparam int unsigned Prev = (i + MaxChannels - 1) % MaxChannels;

    assign token_in[i] = token_out[Prev];

    dpzz_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .home_i  (i == 0),
      .token_i (token_in[i]),
      .token_o (token_out[i]),
      .ctrl_i  (cell_ctrl),
      .ref_i   (ref_chain[i]),
      .ref_o   (ref_chain[i+1])
    );
  end

  dpzz_datapath u_datapath (
    .sample_i      (in_i.sample),
    .ref_i         (ref_chain[MaxChannels]),
    .direction_i   (direction_q),
    .passthrough_i (passthrough),
    .result_o      (result),
    .new_ref_o     (new_ref)
  );

  // output register and skid stage
  always_comb begin
    out_valid_d  = out_valid_q;
    out_byte_d   = out_byte_q;
    out_last_d   = out_last_q;
    skid_valid_d = skid_valid_q;
    skid_byte_d  = skid_byte_q;
    skid_last_d  = skid_last_q;
    if (!out_valid_q || out_fire) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_byte_d   = skid_byte_q;
        out_last_d   = skid_last_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = in_fire;
        out_byte_d  = result;
        out_last_d  = in_i.last_of_image;
      end
    end else if (in_fire) begin
      skid_valid_d = 1'b1;
      skid_byte_d  = result;
      skid_last_d  = in_i.last_of_image;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q  <= out_byte_d;
    out_last_q  <= out_last_d;
    skid_byte_q <= skid_byte_d;
    skid_last_q <= skid_last_d;
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.out_byte = out_byte_q;
  assign out_o.out_last = out_last_q;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry without output entry");

  a_token_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(token_out))
    else $error("channel token lost or duplicated");

  a_warm_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    warm_q <= WarmW'(MaxChannels))
    else $error("warm-up count out of range");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.last_of_image) |=> (warm_q == '0 && token_out[0]))
    else $error("end of image did not restart warm-up");
`endif

endmodule

FILE: dv/tb.sv
// testbench for the dpcm zigzag pixel codec: directed and random byte streams with a scoreboard
`timescale 1ns / 1ps

module tb;
  import dpzz_pkg::*;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned PhaseItems   = 100;
  localparam int unsigned RandomPhases = 16;
  localparam int unsigned IdlePct      = 24;

  typedef struct packed {
    data_t out_byte;
    logic  out_last;
  } codec_result_t;

  class pixel_code_checker;
    data_t         chan_ref [MaxChannels];
    int unsigned   chan_idx;
    int unsigned   warm_cnt;
    dir_e          direction;
    logic          color_mode;
    codec_result_t expected_bytes [$];
    int unsigned   errs;

    function new();
      foreach (chan_ref[i]) chan_ref[i] = '0;
      chan_idx   = 0;
      warm_cnt   = 0;
      direction  = DIR_ENCODE;
      color_mode = 1'b0;
      errs       = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic val);
      case (idx)
        CFG_DIRECTION:  direction = dir_e'(val);
        CFG_COLOR_MODE: color_mode = val;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_bytes.size();
    endfunction

    // work out the byte the codec owes for one accepted request
    function void note_request(data_t sample, logic last);
      int unsigned   nch;
      int unsigned   ch;
      int            diff;
      int            half;
      int            code;
      int            delta;
      int            sum;
      codec_result_t res;
      nch = color_mode ? MaxChannels : 1;
      ch  = (chan_idx < nch) ? chan_idx : 0;
      if (warm_cnt < nch) begin
        res.out_byte = sample;
        chan_ref[ch] = sample;
        warm_cnt++;
      end else if (direction == DIR_ENCODE) begin
        diff = int'(sample) - int'(chan_ref[ch]);
        half = diff / 2;
        code = (half >= 0) ? 2 * half : -2 * half - 1;
        res.out_byte = data_t'(code);
        chan_ref[ch] = data_t'(int'(chan_ref[ch]) + 2 * half);
      end else begin
        delta = sample[0] ? -(int'(sample) + 1) : int'(sample);
        sum   = int'(chan_ref[ch]) + delta;
        if (sum > 255) begin
          sum = 255;
        end else if (sum < 0) begin
          sum = sum + 256;
        end
        res.out_byte = data_t'(sum);
        chan_ref[ch] = res.out_byte;
      end
      res.out_last = last;
      chan_idx = (ch + 1 >= nch) ? 0 : ch + 1;
      if (last) begin
        chan_idx = 0;
        warm_cnt = 0;
      end
      expected_bytes.push_back(res);
    endfunction

    function void check_result(data_t got_byte, logic got_last);
      codec_result_t exp_res;
      if (expected_bytes.size() == 0) begin
        $error("unexpected result: out_byte %0d, out_last %0d", got_byte, got_last);
        errs++;
        return;
      end
      exp_res = expected_bytes.pop_front();
      if (got_byte !== exp_res.out_byte) begin
        $error("out_byte mismatch: expected %0d, actual %0d", exp_res.out_byte, got_byte);
        errs++;
      end
      if (got_last !== exp_res.out_last) begin
        $error("out_last mismatch: expected %0d, actual %0d", exp_res.out_last, got_last);
        errs++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  dpzz_in_if  in_ch ();
  dpzz_out_if out_ch ();

  dpcm_zigzag_pixel_codec i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  pixel_code_checker sb = new();

  bit          steady;
  int unsigned hold_cnt;
  int unsigned cycle_cnt;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_idx             = '0;
    cfg_wdata           = '0;
    in_ch.valid         = 1'b0;
    in_ch.sample        = '0;
    in_ch.last_of_image = 1'b0;
    out_ch.ready        = 1'b0;
    steady              = 1'b0;
    hold_cnt            = 0;
    cycle_cnt           = 0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver side, with long hold-offs on request
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      out_ch.ready <= 1'b0;
      hold_cnt     <= hold_cnt - 1;
    end else if (steady) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= IdlePct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      sb.note_request(in_ch.sample, in_ch.last_of_image);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_result(out_ch.out_byte, out_ch.out_last);
    end
  end

  task automatic idle_input(int unsigned n);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic push_byte(data_t s, logic l);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < IdlePct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.sample        <= s;
    in_ch.last_of_image <= l;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    idle_input(1);
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(dir_e dir, logic color);
    drain();
    write_reg(CFG_DIRECTION, dir);
    write_reg(CFG_COLOR_MODE, color);
  endtask

  function automatic data_t pick_sample();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'd255;
    if (r < 6 && sb.direction == DIR_DECODE) return data_t'($urandom_range(0, 15));
    return data_t'($urandom_range(0, 255));
  endfunction

  task automatic send_image(int unsigned len, bit close);
    for (int unsigned i = 0; i < len; i++) begin
      push_byte(pick_sample(), close && (i == len - 1));
    end
  endtask

  initial begin
    int unsigned sent;
    int unsigned len;
    bit          close;
    bit          held;
    dir_e        dir;
    logic        color;

    held = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    configure(DIR_ENCODE, 1'b0);
    push_byte(8'd0, 1'b0);
    push_byte(8'd255, 1'b0);
    push_byte(8'd0, 1'b0);
    push_byte(8'd1, 1'b0);
    push_byte(8'd128, 1'b1);

    configure(DIR_DECODE, 1'b0);
    push_byte(8'd0, 1'b0);
    push_byte(8'd3, 1'b0);
    push_byte(8'd254, 1'b0);
    push_byte(8'd255, 1'b0);
    push_byte(8'd1, 1'b0);
    push_byte(8'd0, 1'b1);

    // short image, then a full color image
    configure(DIR_ENCODE, 1'b1);
    push_byte(8'd10, 1'b0);
    push_byte(8'd20, 1'b1);
    push_byte(8'd255, 1'b0);
    push_byte(8'd0, 1'b0);
    push_byte(8'd128, 1'b0);
    push_byte(8'd0, 1'b0);
    push_byte(8'd255, 1'b0);
    push_byte(8'd127, 1'b0);
    push_byte(8'd200, 1'b0);
    push_byte(8'd1, 1'b1);

    // mode change in the middle of an image
    configure(DIR_DECODE, 1'b1);
    push_byte(8'd77, 1'b1);
    push_byte(8'd50, 1'b0);
    push_byte(8'd60, 1'b0);
    push_byte(8'd70, 1'b0);
    push_byte(8'd5, 1'b0);
    configure(DIR_ENCODE, 1'b0);
    push_byte(8'd33, 1'b1);

    for (int unsigned p = 0; p < RandomPhases; p++) begin
      if (p < 4) begin
        dir   = dir_e'(p[0]);
        color = p[1];
      end else begin
        dir   = dir_e'($urandom_range(0, 1));
        color = 1'($urandom_range(0, 1));
      end
      configure(dir, color);
      steady = (p == 3);
      sent   = 0;
      while (sent < PhaseItems) begin
        if (p == 6 && sent >= 20 && !held) begin
          hold_cnt = 300;
          held     = 1'b1;
        end
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
        if (len > PhaseItems - sent) begin
          len = PhaseItems - sent;
        end
        close = (sent + len < PhaseItems) || $urandom_range(0, 1);
        send_image(len, close);
        sent += len;
      end
      steady = 1'b0;
    end

    drain();
    repeat (10) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d expected results never arrived", sb.pending());
      sb.errs++;
    end
    if (sb.errs == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/dpzz_pkg.sv
hw/rtl/dpzz_if.sv
hw/rtl/dpzz_cell.sv
hw/rtl/dpzz_datapath.sv
hw/rtl/dpzz_pixel_codec_top.sv
dv/tb.sv
